// ===== src/hpi_pkg.sv =====
package hpi_pkg;

   localparam int DEF_MAX_WIDTH = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;

   localparam int PIXEL_BITS = 8;
   localparam int DIM_BITS = 12;
   localparam int CSR_INDEX_BITS = 1;
   localparam int RESULT_BITS = 3 * PIXEL_BITS;

   localparam logic [DIM_BITS-1:0] DIM_RESET = 12'd2048;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;

endpackage

// ===== src/half_pixel_interpolator_top.sv =====
// Half-pixel interpolator for a luma stream.
// The req_ channel takes one 8-bit pixel per word in raster order. The rsp_
// channel returns one word per pixel with the averages against the pixel
// above, the pixel to the left and the up-left square of four pixels.
// The csr_ port sets frame width (index 0) and height (index 1); any write
// restarts the frame at row zero, column zero.
// Each pixel is registered in the input stage and its result in the output
// register. While the receiver takes results, one word is accepted and one result
// delivered per cycle, set by the single read port and single write port of the
// line store, which is read when the pixel is taken and written when its result
// moves to the output register.
// A synchronous reset empties the pipeline, sets both dimensions to 2048 and
// restarts the frame; the line store is not cleared, since row zero writes
// every entry before a later row reads it.
// When the receiver stalls, the result stays in the output register, one more
// pixel is held in the input stage, and req_tready falls after that.
module half_pixel_interpolator_top #(
   parameter int MAX_WIDTH = hpi_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = hpi_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: pixel.
   input  logic [hpi_pkg::PIXEL_BITS-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: up_average, left_average, diagonal_average.
   output logic [hpi_pkg::RESULT_BITS-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [hpi_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [hpi_pkg::DIM_BITS-1:0]        csr_wdata
);

   localparam int PB = hpi_pkg::PIXEL_BITS;
   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WCW = (hpi_pkg::DIM_BITS > $clog2(MAX_WIDTH + 1)) ?
                        hpi_pkg::DIM_BITS : $clog2(MAX_WIDTH + 1);
   localparam int HCW = (hpi_pkg::DIM_BITS > $clog2(MAX_HEIGHT + 1)) ?
                        hpi_pkg::DIM_BITS : $clog2(MAX_HEIGHT + 1);

   logic [hpi_pkg::DIM_BITS-1:0] width_ff, height_ff;
   logic [CW-1:0]                col_ff, col_in;
   logic [RW-1:0]                row_ff, row_in;
   logic [WCW-1:0]               w_eff, col_next;
   logic [HCW-1:0]               h_eff, row_next;

   logic                         s1_valid_ff;
   logic [PB-1:0]                s1_pixel_ff;
   logic [CW-1:0]                s1_col_ff;
   logic                         s1_first_row_ff, s1_first_col_ff;
   logic [PB-1:0]                above_ff;

   logic [PB-1:0]                left_pixel_ff, above_left_ff;
   logic                         out_valid_ff;
   logic [hpi_pkg::RESULT_BITS-1:0] out_data_ff, out_data_in;

   logic [PB-1:0]                row_store [0:MAX_WIDTH-1];

   logic                         accept, advance;
   logic [PB:0]                  up_sum, left_sum;
   logic [PB+1:0]                diag_sum;
   logic [PB-1:0]                up_avg, left_avg, diag_avg;

   assign advance = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WCW'(1);
      end else if (WCW'(width_ff) > WCW'(MAX_WIDTH)) begin
         w_eff = WCW'(MAX_WIDTH);
      end else begin
         w_eff = WCW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HCW'(1);
      end else if (HCW'(height_ff) > HCW'(MAX_HEIGHT)) begin
         h_eff = HCW'(MAX_HEIGHT);
      end else begin
         h_eff = HCW'(height_ff);
      end
      col_next = WCW'(col_ff) + WCW'(1);
      row_next = HCW'(row_ff) + HCW'(1);
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_next >= w_eff) begin
            col_in = '0;
            if (row_next >= h_eff) begin
               row_in = '0;
            end else begin
               row_in = row_next[RW-1:0];
            end
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   always_comb begin
      up_sum = {1'b0, s1_pixel_ff} + {1'b0, above_ff};
      left_sum = {1'b0, s1_pixel_ff} + {1'b0, left_pixel_ff};
      diag_sum = {2'b00, s1_pixel_ff} + {2'b00, left_pixel_ff}
               + {2'b00, above_ff} + {2'b00, above_left_ff};
      up_avg = s1_first_row_ff ? s1_pixel_ff : up_sum[PB:1];
      left_avg = s1_first_col_ff ? s1_pixel_ff : left_sum[PB:1];
      if (s1_first_row_ff) begin
         diag_avg = left_avg;
      end else if (s1_first_col_ff) begin
         diag_avg = up_avg;
      end else begin
         diag_avg = diag_sum[PB+1:2];
      end
      out_data_in = {diag_avg, left_avg, up_avg};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= hpi_pkg::DIM_RESET;
         height_ff <= hpi_pkg::DIM_RESET;
         col_ff <= '0;
         row_ff <= '0;
         left_pixel_ff <= '0;
         above_left_ff <= '0;
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               hpi_pkg::CSR_FRAME_WIDTH: width_ff <= csr_wdata;
               hpi_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
            col_ff <= '0;
            row_ff <= '0;
            left_pixel_ff <= '0;
            above_left_ff <= '0;
         end else begin
            col_ff <= col_in;
            row_ff <= row_in;
            if (advance) begin
               left_pixel_ff <= s1_pixel_ff;
               above_left_ff <= above_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_tdata;
         s1_col_ff <= col_ff;
         s1_first_row_ff <= (row_ff == '0);
         s1_first_col_ff <= (col_ff == '0);
         if (advance && (s1_col_ff == col_ff)) begin
            above_ff <= s1_pixel_ff;
         end else begin
            above_ff <= row_store[col_ff];
         end
      end
      if (advance) begin
         row_store[s1_col_ff] <= s1_pixel_ff;
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;

endmodule

// ===== src/hpi_checker.sv =====
module hpi_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [hpi_pkg::PIXEL_BITS-1:0]      req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [hpi_pkg::RESULT_BITS-1:0]     rsp_tdata,
   input logic                                csr_we,
   input logic [hpi_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input logic [hpi_pkg::DIM_BITS-1:0]        csr_wdata
);

   // A stalled result word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // The pipeline is empty after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word present after reset");

   // The input side only blocks when the output register is full and stalled.
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input blocked without a stalled result");

   // A pixel taken while the output register is empty passes the input stage and then raises rsp_tvalid.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("result word missing after accepted pixel");

endmodule

bind half_pixel_interpolator_top hpi_checker u_hpi_checker (.*);

// ===== tb/half_pixel_interpolator_top_test.sv =====
module half_pixel_interpolator_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH = hpi_pkg::DEF_MAX_WIDTH;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 6;
   localparam int unsigned RANDOM_ITEMS = 900;
   localparam int unsigned CALM_ITEMS = 150;
   localparam int unsigned MAX_PHASE_ITEMS = 120;
   localparam int unsigned REPORT_LIMIT = 200;
   localparam int unsigned WIDE_ROW_ITEMS = 48;
   localparam logic [hpi_pkg::DIM_BITS-1:0] DIM_ALL_ONES = '1;

   typedef struct packed {
      logic [hpi_pkg::PIXEL_BITS-1:0] diagonal_avg;
      logic [hpi_pkg::PIXEL_BITS-1:0] left_avg;
      logic [hpi_pkg::PIXEL_BITS-1:0] up_avg;
   } averages_type;

   class interp_checker;
      logic [hpi_pkg::PIXEL_BITS-1:0] line_store [LINE_DEPTH];
      logic [hpi_pkg::PIXEL_BITS-1:0] left_pixel;
      logic [hpi_pkg::PIXEL_BITS-1:0] above_left;
      int unsigned col_pos;
      int unsigned row_pos;
      logic [hpi_pkg::DIM_BITS-1:0] width_reg;
      logic [hpi_pkg::DIM_BITS-1:0] height_reg;
      averages_type expected_averages [$];
      int unsigned errors;
      int unsigned checked;

      function new();
         width_reg = hpi_pkg::DIM_RESET;
         height_reg = hpi_pkg::DIM_RESET;
         errors = 0;
         checked = 0;
         restart();
      endfunction

      function void restart();
         left_pixel = '0;
         above_left = '0;
         col_pos = 0;
         row_pos = 0;
      endfunction

      function int unsigned dim_of(logic [hpi_pkg::DIM_BITS-1:0] value,
                                   int unsigned limit);
         if (value == '0) return 1;
         if (value > limit) return limit;
         return value;
      endfunction

      function int unsigned frame_area();
         return dim_of(width_reg, hpi_pkg::DEF_MAX_WIDTH)
                * dim_of(height_reg, hpi_pkg::DEF_MAX_HEIGHT);
      endfunction

      function int unsigned pending();
         return expected_averages.size();
      endfunction

      function void note_register(logic [hpi_pkg::CSR_INDEX_BITS-1:0] index,
                                  logic [hpi_pkg::DIM_BITS-1:0] value);
         if (index == hpi_pkg::CSR_FRAME_WIDTH) begin
            width_reg = value;
         end else if (index == hpi_pkg::CSR_FRAME_HEIGHT) begin
            height_reg = value;
         end
         restart();
      endfunction

      function void note_pixel(logic [hpi_pkg::PIXEL_BITS-1:0] pixel);
         int unsigned w;
         int unsigned h;
         int unsigned col;
         int unsigned cur;
         int unsigned above;
         averages_type result;
         w = dim_of(width_reg, hpi_pkg::DEF_MAX_WIDTH);
         h = dim_of(height_reg, hpi_pkg::DEF_MAX_HEIGHT);
         col = (col_pos >= w) ? 0 : col_pos;
         cur = pixel;
         above = line_store[col];
         result.up_avg = (row_pos > 0) ?
                         hpi_pkg::PIXEL_BITS'((cur + above) >> 1) : pixel;
         result.left_avg = (col > 0) ?
                           hpi_pkg::PIXEL_BITS'((cur + left_pixel) >> 1) : pixel;
         if (col > 0 && row_pos > 0) begin
            result.diagonal_avg =
               hpi_pkg::PIXEL_BITS'((cur + left_pixel + above + above_left) >> 2);
         end else if (row_pos == 0) begin
            result.diagonal_avg = result.left_avg;
         end else begin
            result.diagonal_avg = result.up_avg;
         end
         expected_averages.push_back(result);

         above_left = line_store[col];
         left_pixel = pixel;
         line_store[col] = pixel;
         col++;
         if (col >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
         end else begin
            col_pos = col;
         end
      endfunction

      function void compare_field(string name, logic [hpi_pkg::PIXEL_BITS-1:0] want,
                                  logic [hpi_pkg::PIXEL_BITS-1:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(averages_type actual);
         averages_type want;
         if (expected_averages.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: result word expected none actual %h", $time, actual);
            return;
         end
         want = expected_averages.pop_front();
         checked++;
         compare_field("up_average", want.up_avg, actual.up_avg);
         compare_field("left_average", want.left_avg, actual.left_avg);
         compare_field("diagonal_average", want.diagonal_avg, actual.diagonal_avg);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [hpi_pkg::PIXEL_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [hpi_pkg::RESULT_BITS-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [hpi_pkg::CSR_INDEX_BITS-1:0] csr_index = hpi_pkg::CSR_FRAME_WIDTH;
   logic [hpi_pkg::DIM_BITS-1:0] csr_wdata = '0;

   interp_checker averages_check;
   bit idling = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned pixels_sent = 0;
   int unsigned geometries = 0;
   int stall_left = 0;

   half_pixel_interpolator_top uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (csr_we) averages_check.note_register(csr_index, csr_wdata);
         if (req_tvalid && req_tready) averages_check.note_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready) averages_check.check_result(rsp_tdata);
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!idling) begin
         stall_left = 0;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [hpi_pkg::PIXEL_BITS-1:0] random_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return hpi_pkg::PIXEL_BITS'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [hpi_pkg::DIM_BITS-1:0] random_dim(int unsigned common_max);
      case ($urandom_range(0, 11))
         0: return '0;
         1: return hpi_pkg::DIM_BITS'($urandom_range(hpi_pkg::DEF_MAX_WIDTH + 1, 4095));
         2: return hpi_pkg::DIM_BITS'($urandom_range(13, 64));
         default: return hpi_pkg::DIM_BITS'($urandom_range(1, common_max));
      endcase
   endfunction

   task automatic send_pixel(input logic [hpi_pkg::PIXEL_BITS-1:0] value);
      int gap;
      if (idling && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (averages_check.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(input logic [hpi_pkg::DIM_BITS-1:0] width_value,
                               input logic [hpi_pkg::DIM_BITS-1:0] height_value);
      csr_we <= 1'b1;
      csr_index <= hpi_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= width_value;
      @(posedge clock);
      csr_index <= hpi_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= height_value;
      @(posedge clock);
      csr_we <= 1'b0;
      geometries++;
   endtask

   localparam logic [hpi_pkg::PIXEL_BITS-1:0] SQUARE_PIXELS [12] = '{
      8'd0, 8'd255, 8'd255,
      8'd255, 8'd0, 8'd255,
      8'd255, 8'd255, 8'd0,
      8'd255, 8'd255, 8'd255
   };

   initial begin
      int unsigned area;
      int unsigned count;
      int unsigned random_done;
      averages_check = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      idling = 1'b1;

      // The reset geometry is a 2048-wide frame, so these words all sit on row zero.
      send_pixel('0);
      send_pixel('1);
      repeat (4) send_pixel(random_pixel());
      drain();

      // A 3x3 frame with extremes on both edges, then the wrap back to row zero.
      set_geometry(hpi_pkg::DIM_BITS'(3), hpi_pkg::DIM_BITS'(3));
      for (int i = 0; i < 12; i++) send_pixel(SQUARE_PIXELS[i]);
      drain();

      // Zero dimensions act as one, so every word is the first pixel of a frame.
      set_geometry('0, '0);
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd128);
      drain();

      // A single column with a saturated height.
      set_geometry(hpi_pkg::DIM_BITS'(1), DIM_ALL_ONES);
      send_pixel(8'd255);
      send_pixel(8'd1);
      send_pixel(8'd0);
      send_pixel(8'd254);
      drain();

      // A saturated width keeps these words on row zero.
      set_geometry(DIM_ALL_ONES, hpi_pkg::DIM_BITS'(2));
      repeat (WIDE_ROW_ITEMS) send_pixel(random_pixel());
      drain();

      random_done = 0;
      while (random_done < RANDOM_ITEMS) begin
         idling = (random_done + CALM_ITEMS < RANDOM_ITEMS) && ($urandom_range(0, 3) != 0);
         set_geometry(random_dim(12), random_dim(6));
         area = averages_check.frame_area();
         count = $urandom_range(1, (2 * area + 3 > MAX_PHASE_ITEMS) ?
                                   MAX_PHASE_ITEMS : 2 * area + 3);
         repeat (count) send_pixel(random_pixel());
         random_done += count;
         drain();
      end

      $display("Checked %0d result words from %0d pixels over %0d frame geometries.",
               averages_check.checked, pixels_sent, geometries);
      $display("Frames ranged from single pixels to saturated rows, with idle and stall bursts.");
      if (averages_check.errors == 0 && averages_check.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== half_pixel_interpolator_top.f =====
src/hpi_pkg.sv
src/half_pixel_interpolator_top.sv
src/hpi_checker.sv
tb/half_pixel_interpolator_top_test.sv
